// ----- rtl/cdr_pkg.sv -----
`timescale 1ns / 1ps

package cdr_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int PIX_W         = 32;
  localparam int IMG_W_W       = 13;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_IDX_W     = 2;

  localparam logic [PIX_W-1:0]   OPAQUE_BLACK       = 32'hFF00_0000;
  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST    = 13'd4096;
  localparam logic [PIX_W-1:0]   TERRAIN_COLOR_RST  = '0;
  localparam logic [PIX_W-1:0]   FILL_COLOR_RST     = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH,
    REG_TERRAIN_COLOR,
    REG_FILL_COLOR
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             padding;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_pixel;
    logic             solid;
    logic             frame_last;
  } out_item_t;

  typedef struct packed {
    logic emit;
    logic rs2;
    logic last;
    logic pad;
  } step_t;

endpackage

// ----- rtl/cdr_ctrl.sv -----
`timescale 1ns / 1ps

module cdr_ctrl #(
  parameter int MAX_WIDTH = cdr_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic                        padding,
  input  logic [cdr_pkg::IMG_W_W-1:0] image_width,
  output logic                        load,
  output logic [CW-1:0]               col,
  output logic [CW-1:0]               right_addr,
  output cdr_pkg::step_t              step
);

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CMPW = (WW > cdr_pkg::IMG_W_W) ? WW : cdr_pkg::IMG_W_W;

  typedef enum logic [1:0] {
    ROW_NONE,
    ROW_ONE,
    ROW_MANY
  } row_t;

  row_t            row_r, row_nxt;
  logic [CW-1:0]   column_r, column_nxt;
  logic [CMPW-1:0] w_raw;
  logic [WW-1:0]   w_eff;
  logic [CW-1:0]   last_idx;
  logic            last;

  always_comb begin
    w_raw = CMPW'(image_width);
    if (w_raw == '0) begin
      w_eff = WW'(1);
    end else if (w_raw > CMPW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w_raw);
    end
    last_idx = CW'(w_eff - WW'(1));
    col      = (WW'(column_r) >= w_eff) ? last_idx : column_r;
    last     = (col == last_idx);
    right_addr = last ? '0 : CW'(col + CW'(1));
    load     = accept && !(padding && row_r == ROW_NONE);
    step.emit = (row_r != ROW_NONE);
    step.rs2  = (row_r == ROW_MANY);
    step.last = last;
    step.pad  = padding;
  end

  always_comb begin
    row_nxt    = row_r;
    column_nxt = column_r;
    if (load) begin
      if (last) begin
        column_nxt = '0;
        if (padding) begin
          row_nxt = ROW_NONE;
        end else begin
          case (row_r)
            ROW_NONE: row_nxt = ROW_ONE;
            ROW_ONE:  row_nxt = ROW_MANY;
            default:  row_nxt = ROW_MANY;
          endcase
        end
      end else begin
        column_nxt = CW'(col + CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r    <= ROW_NONE;
      column_r <= '0;
    end else begin
      row_r    <= row_nxt;
      column_r <= column_nxt;
    end
  end

endmodule

// ----- rtl/cdr_line_buf.sv -----
`timescale 1ns / 1ps

module cdr_line_buf #(
  parameter int MAX_WIDTH = cdr_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      load,
  input  logic [CW-1:0]             col,
  input  logic [CW-1:0]             right_addr,
  input  logic [cdr_pkg::PIX_W-1:0] pix_wdata,
  input  logic                      fl_we,
  input  logic [CW-1:0]             fl_addr,
  input  logic                      fl_wdata,
  output logic [cdr_pkg::PIX_W-1:0] center_q,
  output logic [cdr_pkg::PIX_W-1:0] right_q,
  output logic                      above_q
);

  logic [cdr_pkg::PIX_W-1:0] pix_mem [MAX_WIDTH];
  logic                      flag_mem [MAX_WIDTH];
  logic                      flag_rd_r;
  logic                      byp_r;
  logic                      byp_val_r;

  // read-first: center sees the previous row before this transfer overwrites it
  always_ff @(posedge clk) begin
    if (load) begin
      center_q      <= pix_mem[col];
      right_q       <= pix_mem[right_addr];
      pix_mem[col]  <= pix_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (fl_we) begin
      flag_mem[fl_addr] <= fl_wdata;
    end
    if (load) begin
      flag_rd_r <= flag_mem[col];
      byp_r     <= fl_we && (fl_addr == col);
      byp_val_r <= fl_wdata;
    end
  end

  assign above_q = byp_r ? byp_val_r : flag_rd_r;

endmodule

// ----- rtl/cdr_core.sv -----
`timescale 1ns / 1ps

module cdr_core #(
  parameter int MAX_WIDTH = cdr_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  cdr_pkg::step_t            step,
  input  logic [CW-1:0]             col,
  input  logic [cdr_pkg::PIX_W-1:0] pixel,
  input  logic [cdr_pkg::PIX_W-1:0] terrain_color,
  input  logic [cdr_pkg::PIX_W-1:0] fill_color,
  input  logic [cdr_pkg::PIX_W-1:0] center,
  input  logic [cdr_pkg::PIX_W-1:0] right_pix,
  input  logic                      above_flag,
  output logic                      fl_we,
  output logic [CW-1:0]             fl_addr,
  output logic                      fl_wdata,
  output logic                      hold,
  output logic                      out_valid,
  input  logic                      out_stall,
  output cdr_pkg::out_item_t        out_data
);

  logic                      s1_valid_r;
  cdr_pkg::step_t            s1_step_r;
  logic [CW-1:0]             s1_col_r;
  logic [cdr_pkg::PIX_W-1:0] s1_pix_r;
  logic                      left_r;
  logic                      out_valid_r;
  cdr_pkg::out_item_t        out_data_r;
  cdr_pkg::out_item_t        res;
  logic                      adv;
  logic                      center_t;
  logic                      hit;

  always_comb begin
    adv      = !out_valid_r || !out_stall;
    hold     = s1_valid_r && !adv;
    center_t = (center == terrain_color);
    hit      = !center_t &&
               ((s1_step_r.rs2 && above_flag) ||
                (!s1_step_r.pad && s1_pix_r == terrain_color) ||
                left_r ||
                (!s1_step_r.last && right_pix == terrain_color) ||
                center == cdr_pkg::OPAQUE_BLACK);
    res.out_pixel  = hit ? fill_color : center;
    res.solid      = hit;
    res.frame_last = s1_step_r.pad && s1_step_r.last;
    fl_we    = s1_valid_r && adv;
    fl_addr  = s1_col_r;
    fl_wdata = center_t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      left_r      <= 1'b0;
    end else begin
      if (!hold) begin
        s1_valid_r <= load;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r && s1_step_r.emit;
        if (s1_valid_r) begin
          left_r <= s1_step_r.last ? 1'b0 : center_t;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_step_r <= step;
      s1_col_r  <= col;
      s1_pix_r  <= pixel;
    end
    if (adv && s1_valid_r) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/cross_dilate_recolor.sv -----
`timescale 1ns / 1ps

// channel | ports                                   | direction
// --------+-----------------------------------------+----------
// input   | in_valid, in_stall, in_data             | pixels in, raster order
// result  | out_valid, out_stall, out_data          | pixels out, one row behind
// config  | cfg_wr_en, cfg_index, cfg_wdata         | register writes
//
// One pixel per cycle sustained while no result is held by out_stall; the result a transfer
// causes is registered in stage 1, then in the output register. Both line buffers are
// single-write memories with registered reads. rst_n is synchronous; line buffer contents
// are not cleared. in_stall rises only while a finished result is held by out_stall.

module cross_dilate_recolor #(
  parameter int MAX_WIDTH = cdr_pkg::MAX_WIDTH_DEF,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  cdr_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output cdr_pkg::out_item_t             out_data,
  input  logic                           cfg_wr_en,
  input  logic [cdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cdr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [cdr_pkg::IMG_W_W-1:0] image_width_r;
  logic [cdr_pkg::PIX_W-1:0]   terrain_color_r;
  logic [cdr_pkg::PIX_W-1:0]   fill_color_r;

  logic                      accept;
  logic                      load;
  logic [CW-1:0]             col;
  logic [CW-1:0]             right_addr;
  cdr_pkg::step_t            step;
  logic                      fl_we;
  logic [CW-1:0]             fl_addr;
  logic                      fl_wdata;
  logic [cdr_pkg::PIX_W-1:0] center_q;
  logic [cdr_pkg::PIX_W-1:0] right_q;
  logic                      above_q;
  logic                      hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= cdr_pkg::IMAGE_WIDTH_RST;
      terrain_color_r <= cdr_pkg::TERRAIN_COLOR_RST;
      fill_color_r    <= cdr_pkg::FILL_COLOR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        cdr_pkg::REG_IMAGE_WIDTH:   image_width_r   <= cfg_wdata[cdr_pkg::IMG_W_W-1:0];
        cdr_pkg::REG_TERRAIN_COLOR: terrain_color_r <= cfg_wdata[cdr_pkg::PIX_W-1:0];
        cdr_pkg::REG_FILL_COLOR:    fill_color_r    <= cfg_wdata[cdr_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = hold;
  assign accept   = in_valid && !hold;

  cdr_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .padding     (in_data.padding),
    .image_width (image_width_r),
    .load        (load),
    .col         (col),
    .right_addr  (right_addr),
    .step        (step)
  );

  cdr_line_buf #(.MAX_WIDTH(MAX_WIDTH)) u_line_buf (
    .clk        (clk),
    .load       (load),
    .col        (col),
    .right_addr (right_addr),
    .pix_wdata  (in_data.pixel_value),
    .fl_we      (fl_we),
    .fl_addr    (fl_addr),
    .fl_wdata   (fl_wdata),
    .center_q   (center_q),
    .right_q    (right_q),
    .above_q    (above_q)
  );

  cdr_core #(.MAX_WIDTH(MAX_WIDTH)) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (load),
    .step          (step),
    .col           (col),
    .pixel         (in_data.pixel_value),
    .terrain_color (terrain_color_r),
    .fill_color    (fill_color_r),
    .center        (center_q),
    .right_pix     (right_q),
    .above_flag    (above_q),
    .fl_we         (fl_we),
    .fl_addr       (fl_addr),
    .fl_wdata      (fl_wdata),
    .hold          (hold),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

// ----- rtl/cdr_checker.sv -----
`timescale 1ns / 1ps

module cdr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input cdr_pkg::out_item_t             out_data,
  input logic                           cfg_wr_en,
  input logic [cdr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [cdr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [cdr_pkg::PIX_W-1:0] fill_r;
  logic                      in_xfer;

  assign in_xfer = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= cdr_pkg::FILL_COLOR_RST;
    end else if (cfg_wr_en && cfg_index == cdr_pkg::REG_FILL_COLOR) begin
      fill_r <= cfg_wdata[cdr_pkg::PIX_W-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a held result");

  a_solid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.solid |-> out_data.out_pixel == fill_r)
    else $error("solid pixel not in fill color");

  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_xfer, 2))
    else $error("result without an input transfer");

endmodule

bind cross_dilate_recolor cdr_checker u_cdr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data),
  .cfg_wr_en (cfg_wr_en),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata)
);

// ----- test/cross_dilate_recolor_tb.sv -----
`timescale 1ns / 1ps

module cross_dilate_recolor_tb;

  localparam int MAXW = cdr_pkg::MAX_WIDTH_DEF;

  logic                           clk;
  logic                           rst_n     = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_stall;
  cdr_pkg::in_item_t              in_data   = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  cdr_pkg::out_item_t             out_data;
  logic                           cfg_wr_en = 1'b0;
  logic [cdr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [cdr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  cross_dilate_recolor uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cdr_pkg::in_item_t  src_pixels[$];
  cdr_pkg::out_item_t due_results[$];
  int        items_queued  = 0;
  int        results_seen  = 0;
  int        err_count     = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        hold_left     = 0;
  bit        hold_done     = 1'b0;

  logic [cdr_pkg::IMG_W_W-1:0] width_reg   = cdr_pkg::IMAGE_WIDTH_RST;
  logic [cdr_pkg::PIX_W-1:0]   terrain_reg = cdr_pkg::TERRAIN_COLOR_RST;
  logic [cdr_pkg::PIX_W-1:0]   fill_reg    = cdr_pkg::FILL_COLOR_RST;

  bit [cdr_pkg::PIX_W-1:0] line_pix [MAXW];
  bit             line_terr [MAXW];
  int unsigned    col             = 0;
  int unsigned    rows_in         = 0;
  bit             left_is_terrain = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_width(logic [cdr_pkg::IMG_W_W-1:0] raw);
    int unsigned w;
    w = raw;
    if (w == 0) w = 1;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic void dilate_step(cdr_pkg::in_item_t it);
    int unsigned w;
    int unsigned c;
    bit [cdr_pkg::PIX_W-1:0] center;
    bit center_t;
    bit at_end;
    bit t_above;
    bit t_below;
    bit t_right;
    bit t_left;
    cdr_pkg::out_item_t r;
    w = eff_width(width_reg);
    if (it.padding && rows_in == 0) return;
    c = col;
    if (c >= w) c = w - 1;
    at_end = (c + 1 >= w);
    center = line_pix[c];
    center_t = (center == terrain_reg);
    if (rows_in >= 1) begin
      t_above = (rows_in >= 2) && line_terr[c];
      t_below = !it.padding && (it.pixel_value == terrain_reg);
      t_right = !at_end && (line_pix[c + 1] == terrain_reg);
      t_left  = (c > 0) && left_is_terrain;
      r.out_pixel = center;
      r.solid = 1'b0;
      if (!center_t && (t_above || t_below || t_left || t_right ||
                        center == cdr_pkg::OPAQUE_BLACK)) begin
        r.out_pixel = fill_reg;
        r.solid = 1'b1;
      end
      r.frame_last = it.padding && at_end;
      due_results.push_back(r);
    end
    left_is_terrain = center_t;
    line_terr[c] = center_t;
    line_pix[c] = it.pixel_value;
    if (at_end) begin
      col = 0;
      left_is_terrain = 1'b0;
      if (it.padding) rows_in = 0;
      else if (rows_in < 2) rows_in++;
    end else begin
      col = c + 1;
    end
  endfunction

  always @(posedge clk) begin : drive
    logic              nxt_valid;
    cdr_pkg::in_item_t nxt_data;
    nxt_valid = in_valid;
    nxt_data  = in_data;
    if (!rst_n) begin
      nxt_valid = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        dilate_step(in_data);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid && src_pixels.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt_valid = 1'b1;
        nxt_data  = src_pixels.pop_front();
      end
    end
    in_valid <= nxt_valid;
    in_data  <= nxt_data;
  end

  always @(posedge clk) begin : watch
    cdr_pkg::out_item_t want;
    logic               nxt_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $error("unexpected transfer: out_pixel %h solid %b frame_last %b",
                 out_data.out_pixel, out_data.solid, out_data.frame_last);
          err_count++;
        end else begin
          want = due_results.pop_front();
          if (out_data.out_pixel !== want.out_pixel) begin
            $error("out_pixel: expected %h, got %h", want.out_pixel, out_data.out_pixel);
            err_count++;
          end
          if (out_data.solid !== want.solid) begin
            $error("solid: expected %b, got %b", want.solid, out_data.solid);
            err_count++;
          end
          if (out_data.frame_last !== want.frame_last) begin
            $error("frame_last: expected %b, got %b", want.frame_last, out_data.frame_last);
            err_count++;
          end
        end
      end
      // hold off long enough to back the block up into its input
      if (!hold_done && results_seen >= 400) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      nxt_stall = 1'b1;
    end else begin
      nxt_stall = ($urandom_range(0, 99) < recv_idle_pct);
    end
    out_stall <= nxt_stall;
  end

  task automatic wait_idle();
    while (src_pixels.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(cdr_pkg::cfg_reg_t idx, logic [cdr_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      cdr_pkg::REG_IMAGE_WIDTH:   width_reg   = val[cdr_pkg::IMG_W_W-1:0];
      cdr_pkg::REG_TERRAIN_COLOR: terrain_reg = val;
      cdr_pkg::REG_FILL_COLOR:    fill_reg    = val;
      default: ;
    endcase
  endtask

  task automatic setup(logic [cdr_pkg::IMG_W_W-1:0] w, logic [cdr_pkg::PIX_W-1:0] terr,
                       logic [cdr_pkg::PIX_W-1:0] fill);
    wait_idle();
    write_reg(cdr_pkg::REG_IMAGE_WIDTH, cdr_pkg::CFG_DATA_W'(w));
    write_reg(cdr_pkg::REG_TERRAIN_COLOR, terr);
    write_reg(cdr_pkg::REG_FILL_COLOR, fill);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic push_item(logic [cdr_pkg::PIX_W-1:0] pix, logic pad);
    cdr_pkg::in_item_t it;
    it.pixel_value = pix;
    it.padding     = pad;
    src_pixels.push_back(it);
    items_queued++;
  endtask

  function automatic logic [cdr_pkg::PIX_W-1:0] pick_pixel();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2: return terrain_reg;
      3:       return cdr_pkg::OPAQUE_BLACK;
      4:       return fill_reg;
      5:       return terrain_reg ^ (32'h1 << $urandom_range(0, 31));
      6:       return '0;
      7:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // leading padding is dropped by the block; mid-row padding only after the first row
  task automatic queue_frame(int unsigned w, int unsigned nrows);
    int unsigned r;
    int unsigned c;
    int unsigned n_lead;
    n_lead = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    for (c = 0; c < n_lead; c++) push_item($urandom, 1'b1);
    for (r = 0; r < nrows; r++) begin
      for (c = 0; c < w; c++) begin
        push_item(pick_pixel(), r > 0 && c + 1 < w && $urandom_range(0, 9) == 0);
      end
    end
    for (c = 0; c < w; c++) push_item($urandom, 1'b1);
  endtask

  task automatic run_random(logic [cdr_pkg::IMG_W_W-1:0] wraw, logic [cdr_pkg::PIX_W-1:0] terr,
                            logic [cdr_pkg::PIX_W-1:0] fill, int budget);
    int start;
    int unsigned w;
    setup(wraw, terr, fill);
    w = eff_width(wraw);
    start = items_queued;
    while (items_queued - start < budget) queue_frame(w, $urandom_range(1, 5));
  endtask

  initial begin
    send_idle_pct = 28;
    recv_idle_pct = 49;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    setup(13'd3, 32'h1234_5678, 32'h00C0_FFEE);
    push_item(32'hDEAD_0001, 1'b1);
    push_item(cdr_pkg::OPAQUE_BLACK, 1'b0);
    push_item(32'h0000_0000, 1'b0);
    push_item(32'h1234_5678, 1'b0);
    push_item(32'h1234_5678, 1'b0);
    push_item(32'hFFFF_FFFF, 1'b1);
    push_item(cdr_pkg::OPAQUE_BLACK, 1'b0);
    push_item(32'h0000_0000, 1'b0);
    push_item(32'h1234_5678, 1'b0);
    push_item(32'h1234_5679, 1'b0);
    push_item(32'h0000_0000, 1'b1);
    push_item(32'hFFFF_FFFF, 1'b1);
    push_item(32'h1234_5678, 1'b1);

    run_random(13'd0, $urandom, $urandom, 270);
    run_random(13'd1, $urandom, $urandom, 270);
    run_random(13'd2, $urandom, $urandom, 270);

    wait_idle();
    send_idle_pct = 49;
    recv_idle_pct = 28;
    run_random(13'd5, cdr_pkg::OPAQUE_BLACK, $urandom, 270);
    run_random(13'd7, 32'h0000_0000, 32'hFFFF_FFFF, 270);

    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(13'd16, 32'hFFFF_FFFF, 32'h0000_0000, 270);
    run_random(13'($urandom_range(3, 40)), $urandom, $urandom, 270);

    wait_idle();
    if (err_count == 0 && due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
